/* sv/sha1s_pkg.sv */
package sha1s_pkg;

   localparam int WORD_W       = 32;
   localparam int NUM_WORDS    = 16;
   localparam int DIGEST_WORDS = 5;
   localparam int NUM_ROUNDS   = 80;
   localparam int OFFSET_W     = 6;
   localparam int ROUND_W      = 7;
   localparam int INDEX_W      = 3;

   localparam logic [OFFSET_W-1:0] LEN_POS    = 6'd56;
   localparam logic [OFFSET_W-1:0] LAST_POS   = 6'd63;
   localparam logic [7:0]          PAD_MARK   = 8'h80;
   localparam logic [INDEX_W-1:0]  LAST_INDEX = 3'd4;
   localparam logic [ROUND_W-1:0]  LAST_ROUND = 7'(NUM_ROUNDS - 1);

   localparam logic [WORD_W-1:0] K_R0 = 32'h5a827999;
   localparam logic [WORD_W-1:0] K_R1 = 32'h6ed9eba1;
   localparam logic [WORD_W-1:0] K_R2 = 32'h8f1bbcdc;
   localparam logic [WORD_W-1:0] K_R3 = 32'hca62c1d6;

   localparam logic [WORD_W-1:0] INIT_CHAIN [DIGEST_WORDS] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SRC_INPUT,
      SRC_MARK,
      SRC_ZERO,
      SRC_LENGTH
   } byte_src_type;

   typedef enum logic [1:0] {
      STAGE_CHOOSE,
      STAGE_PARITY_0,
      STAGE_MAJORITY,
      STAGE_PARITY_1
   } stage_type;

   typedef struct packed {
      logic                put;
      byte_src_type        byte_src;
      logic                absorb;
      logic                round;
      stage_type           stage;
      logic                update;
      logic                emit_load;
      logic [INDEX_W-1:0]  word_idx;
      logic                clear;
   } ctrl_cmd_type;

   typedef struct packed {
      logic block_end;
      logic at_len_pos;
      logic rsp_free;
   } ctrl_status_type;

endpackage

/* sv/sha1s_ctrl.sv */
module sha1s_ctrl
   import sha1s_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic            req_mode,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type            state_ff, state_in;
   state_type            ret_ff, ret_in;
   logic [ROUND_W-1:0]   round_ff, round_in;
   logic [INDEX_W-1:0]   word_ff, word_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         round_ff <= '0;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         round_ff <= round_in;
         word_ff  <= word_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      round_in     = round_ff;
      word_in      = word_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.byte_src = SRC_INPUT;
      cmd.stage    = STAGE_CHOOSE;
      cmd.word_idx = word_ff;

      if (round_ff < ROUND_W'(20)) begin
         cmd.stage = STAGE_CHOOSE;
      end else if (round_ff < ROUND_W'(40)) begin
         cmd.stage = STAGE_PARITY_0;
      end else if (round_ff < ROUND_W'(60)) begin
         cmd.stage = STAGE_MAJORITY;
      end else begin
         cmd.stage = STAGE_PARITY_1;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_mode) begin
                  state_in = ST_PAD_MARK;
               end else begin
                  cmd.put      = 1'b1;
                  cmd.absorb   = 1'b1;
                  cmd.byte_src = SRC_INPUT;
                  if (status.block_end) begin
                     state_in = ST_ROUND;
                     ret_in   = ST_IDLE;
                  end
               end
            end
         end
         ST_PAD_MARK: begin
            cmd.put      = 1'b1;
            cmd.byte_src = SRC_MARK;
            if (status.block_end) begin
               state_in = ST_ROUND;
               ret_in   = ST_PAD_ZERO;
            end else begin
               state_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_ZERO: begin
            if (status.at_len_pos) begin
               state_in = ST_PAD_LEN;
            end else begin
               cmd.put      = 1'b1;
               cmd.byte_src = SRC_ZERO;
               if (status.block_end) begin
                  state_in = ST_ROUND;
                  ret_in   = ST_PAD_ZERO;
               end
            end
         end
         ST_PAD_LEN: begin
            cmd.put      = 1'b1;
            cmd.byte_src = SRC_LENGTH;
            if (status.block_end) begin
               state_in = ST_ROUND;
               ret_in   = ST_EMIT;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (round_ff == LAST_ROUND) begin
               round_in = '0;
               state_in = ST_UPDATE;
            end else begin
               round_in = round_ff + ROUND_W'(1);
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ret_ff;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit_load = 1'b1;
               if (word_ff == LAST_INDEX) begin
                  cmd.clear = 1'b1;
                  word_in   = '0;
                  state_in  = ST_IDLE;
               end else begin
                  word_in = word_ff + INDEX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/sha1s_datapath.sv */
module sha1s_datapath
   import sha1s_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         req_byte,
   input  ctrl_cmd_type       cmd,
   output ctrl_status_type    status,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [WORD_W-1:0]  rsp_word,
   output logic [INDEX_W-1:0] rsp_index,
   output logic               rsp_tlast
);

   logic [WORD_W-1:0]   sched_ff [NUM_WORDS];
   logic [WORD_W-1:0]   sched_in [NUM_WORDS];
   logic [WORD_W-1:0]   vars_ff  [DIGEST_WORDS];
   logic [WORD_W-1:0]   vars_in  [DIGEST_WORDS];
   logic [WORD_W-1:0]   chain_ff [DIGEST_WORDS];
   logic [WORD_W-1:0]   chain_in [DIGEST_WORDS];
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [WORD_W-1:0]   count_ff, count_in;
   logic                valid_ff, valid_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic                last_ff, last_in;

   logic [7:0]          put_byte;
   logic [7:0]          len_byte;
   logic [WORD_W-1:0]   next_w;
   logic [WORD_W-1:0]   fval;
   logic [WORD_W-1:0]   kval;
   logic [WORD_W-1:0]   temp;

   assign status.block_end  = (offset_ff == LAST_POS);
   assign status.at_len_pos = (offset_ff == LEN_POS);
   assign status.rsp_free   = !valid_ff || rsp_tready;

   assign rsp_tvalid = valid_ff;
   assign rsp_word   = word_ff;
   assign rsp_index  = index_ff;
   assign rsp_tlast  = last_ff;

   always_comb begin
      case (offset_ff[2:0])
         3'd3:    len_byte = {5'd0, count_ff[31:29]};
         3'd4:    len_byte = count_ff[28:21];
         3'd5:    len_byte = count_ff[20:13];
         3'd6:    len_byte = count_ff[12:5];
         3'd7:    len_byte = {count_ff[4:0], 3'd0};
         default: len_byte = 8'd0;
      endcase
      case (cmd.byte_src)
         SRC_INPUT:  put_byte = req_byte;
         SRC_MARK:   put_byte = PAD_MARK;
         SRC_ZERO:   put_byte = 8'd0;
         SRC_LENGTH: put_byte = len_byte;
         default:    put_byte = 8'd0;
      endcase
   end

   always_comb begin
      case (cmd.stage)
         STAGE_CHOOSE: begin
            fval = vars_ff[3] ^ (vars_ff[1] & (vars_ff[2] ^ vars_ff[3]));
            kval = K_R0;
         end
         STAGE_PARITY_0: begin
            fval = vars_ff[1] ^ vars_ff[2] ^ vars_ff[3];
            kval = K_R1;
         end
         STAGE_MAJORITY: begin
            fval = (vars_ff[1] & vars_ff[2]) | (vars_ff[3] & (vars_ff[1] | vars_ff[2]));
            kval = K_R2;
         end
         STAGE_PARITY_1: begin
            fval = vars_ff[1] ^ vars_ff[2] ^ vars_ff[3];
            kval = K_R3;
         end
         default: begin
            fval = '0;
            kval = '0;
         end
      endcase
      next_w = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
      next_w = {next_w[30:0], next_w[31]};
      temp   = {vars_ff[0][26:0], vars_ff[0][31:27]} + fval + vars_ff[4] + kval
             + sched_ff[0];
   end

   always_comb begin
      sched_in = sched_ff;
      vars_in  = vars_ff;
      if (cmd.put) begin
         for (int i = 0; i < NUM_WORDS - 1; i++) begin
            sched_in[i] = {sched_ff[i][23:0], sched_ff[i+1][31:24]};
         end
         sched_in[NUM_WORDS-1] = {sched_ff[NUM_WORDS-1][23:0], put_byte};
         if (status.block_end) begin
            vars_in = chain_ff;
         end
      end else if (cmd.round) begin
         for (int i = 0; i < NUM_WORDS - 1; i++) begin
            sched_in[i] = sched_ff[i+1];
         end
         sched_in[NUM_WORDS-1] = next_w;
         vars_in[0] = temp;
         vars_in[1] = vars_ff[0];
         vars_in[2] = {vars_ff[1][1:0], vars_ff[1][31:2]};
         vars_in[3] = vars_ff[2];
         vars_in[4] = vars_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
      vars_ff  <= vars_in;
      word_ff  <= word_in;
      index_ff <= index_in;
      last_ff  <= last_in;
   end

   always_comb begin
      chain_in  = chain_ff;
      offset_in = offset_ff;
      count_in  = count_ff;
      valid_in  = valid_ff;
      word_in   = word_ff;
      index_in  = index_ff;
      last_in   = last_ff;
      if (cmd.put) begin
         offset_in = offset_ff + OFFSET_W'(1);
      end
      if (cmd.absorb) begin
         count_in = count_ff + WORD_W'(1);
      end
      if (cmd.update) begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + vars_ff[i];
         end
      end
      if (cmd.emit_load) begin
         valid_in = 1'b1;
         word_in  = chain_ff[cmd.word_idx];
         index_in = cmd.word_idx;
         last_in  = (cmd.word_idx == LAST_INDEX);
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (cmd.clear) begin
         chain_in  = INIT_CHAIN;
         offset_in = '0;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff  <= INIT_CHAIN;
         offset_ff <= '0;
         count_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         chain_ff  <= chain_in;
         offset_ff <= offset_in;
         count_ff  <= count_in;
         valid_ff  <= valid_in;
      end
   end

endmodule

/* sv/sha1_stream_hash.sv */
// Absorb transfer: one byte per cycle while idle; every 64th byte starts a compression (80 rounds, one update).
// The single shared round unit limits the byte rate: no byte is taken while a block is compressed.
// Finish: padding (mark byte, zeros, length field), one or two compressions, then five digest transfers.
// Digest words are emitted after the final chain update, one per ready cycle.
// Reset (synchronous, active high) restores the initial chain value, clears offset,
// byte count and output valid; schedule and round registers are not reset.
module sha1_stream_hash
   import sha1s_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   sha1s_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser[0]),
      .status     (status),
      .cmd        (cmd)
   );

   sha1s_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_byte   (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_tdata),
      .rsp_index  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
